>>> sv/uditmr_pkg.sv
// Package for the up/down interval timer.
// Holds the mode and key codes, the hh:mm:ss and transfer types, and the wrap helpers.
// No dependencies.
package uditmr_pkg;

   localparam logic [6:0] HOUR_LAST = 7'd99;
   localparam logic [5:0] MS_LAST   = 6'd59;
   localparam logic [6:0] START_HR  = 7'd23;

   localparam logic [1:0] BLINK_NONE = 2'd0;
   localparam logic [1:0] BLINK_HR   = 2'd1;
   localparam logic [1:0] BLINK_MIN  = 2'd2;
   localparam logic [1:0] BLINK_SEC  = 2'd3;

   localparam int RSP_W = 32;

   typedef enum logic [3:0] {
      MODE_CLOCK   = 4'd0,
      MODE_SELECT  = 4'd1,
      MODE_EDIT_H  = 4'd2,
      MODE_EDIT_M  = 4'd3,
      MODE_EDIT_S  = 4'd4,
      MODE_STOPPED = 4'd5,
      MODE_PAUSED  = 4'd6,
      MODE_DOWN    = 4'd7,
      MODE_UP      = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      KEY_ENTER = 2'd0,
      KEY_PLUS  = 2'd1,
      KEY_MINUS = 2'd2,
      KEY_START = 2'd3
   } key_type;

   typedef struct packed {
      logic [6:0] h;
      logic [5:0] m;
      logic [5:0] s;
   } hms_type;

   typedef struct packed {
      logic    cmd;
      key_type key;
   } item_type;

   // first field in the highest bits
   typedef struct packed {
      logic [1:0] pad;
      logic       beep;
      logic       buzz;
      logic       colon_on;
      logic       second_blank;
      logic       minute_blank;
      logic       hour_blank;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [6:0] hours;
      logic       direction;
      mode_type   mode;
   } rsp_type;

   function automatic logic [6:0] hr_inc(input logic [6:0] v);
      return (v >= HOUR_LAST) ? 7'd0 : v + 7'd1;
   endfunction

   function automatic logic [6:0] hr_dec(input logic [6:0] v);
      return (v == 7'd0) ? HOUR_LAST : v - 7'd1;
   endfunction

   function automatic logic [5:0] ms_inc(input logic [5:0] v);
      return (v >= MS_LAST) ? 6'd0 : v + 6'd1;
   endfunction

   function automatic logic [5:0] ms_dec(input logic [5:0] v);
      return (v == 6'd0) ? MS_LAST : v - 6'd1;
   endfunction

endpackage

>>> sv/uditmr_state.sv
// Timer state registers and the per-item update (keys and one-second ticks).
// Produces the display word of the updated state.
// Depends on uditmr_pkg.
module uditmr_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  uditmr_pkg::item_type item,
   input  logic                beep_enable,
   output uditmr_pkg::rsp_type disp
);
   import uditmr_pkg::*;

   mode_type   mode_ff,      mode_in;
   logic       down_ff,      down_in;
   hms_type    count_ff,     count_in;
   hms_type    target_ff,    target_in;
   hms_type    reload_ff,    reload_in;
   logic       buzz_seen_ff, buzz_seen_in;
   logic       buzz_on_ff,   buzz_on_in;
   logic [1:0] blink_ff,     blink_in;

   logic       at_target;
   logic       edit;
   logic [5:0] sec_up;
   logic [5:0] min_up;

   assign at_target = (count_ff == target_ff);
   assign sec_up    = ms_inc(count_ff.s);
   assign min_up    = ms_inc(count_ff.m);

   // next state
   always_comb begin
      mode_in      = mode_ff;
      down_in      = down_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      reload_in    = reload_ff;
      buzz_seen_in = buzz_seen_ff;
      buzz_on_in   = buzz_on_ff;
      blink_in     = blink_ff;
      if (step_en && item.cmd) begin
         unique case (mode_ff)
            MODE_SELECT: begin
               unique case (item.key)
                  KEY_ENTER: mode_in = MODE_CLOCK;
                  KEY_PLUS: begin
                     down_in = 1'b0;
                     mode_in = MODE_EDIT_H;
                  end
                  KEY_MINUS: begin
                     down_in = 1'b1;
                     mode_in = MODE_EDIT_H;
                  end
                  KEY_START: begin
                     down_in   = 1'b0;
                     target_in = '{h: START_HR, m: MS_LAST, s: MS_LAST};
                     count_in  = '0;
                     mode_in   = MODE_UP;
                  end
                  default: ;
               endcase
            end
            MODE_EDIT_H, MODE_EDIT_M, MODE_EDIT_S: begin
               unique case (item.key)
                  KEY_PLUS: begin
                     if (mode_ff == MODE_EDIT_H) count_in.h = hr_inc(count_ff.h);
                     else if (mode_ff == MODE_EDIT_M) count_in.m = ms_inc(count_ff.m);
                     else count_in.s = ms_inc(count_ff.s);
                  end
                  KEY_MINUS: begin
                     if (mode_ff == MODE_EDIT_H) count_in.h = hr_dec(count_ff.h);
                     else if (mode_ff == MODE_EDIT_M) count_in.m = ms_dec(count_ff.m);
                     else count_in.s = ms_dec(count_ff.s);
                  end
                  KEY_ENTER: begin
                     if (mode_ff == MODE_EDIT_H) begin
                        mode_in = MODE_EDIT_M;
                     end else if (mode_ff == MODE_EDIT_M) begin
                        mode_in = MODE_EDIT_S;
                     end else begin
                        // enter on seconds starts like start_stop
                        if (!down_ff) begin
                           target_in = count_ff;
                           count_in  = '0;
                        end else begin
                           target_in = '0;
                           reload_in = count_ff;
                        end
                        mode_in = MODE_PAUSED;
                     end
                  end
                  KEY_START: begin
                     if (!down_ff) begin
                        target_in = count_ff;
                        count_in  = '0;
                     end else begin
                        target_in = '0;
                        reload_in = count_ff;
                     end
                     mode_in = MODE_PAUSED;
                  end
                  default: ;
               endcase
            end
            MODE_STOPPED, MODE_PAUSED: begin
               if (item.key == KEY_ENTER) begin
                  mode_in = MODE_CLOCK;
               end else if ((mode_ff == MODE_STOPPED && item.key == KEY_START) ||
                            (mode_ff == MODE_PAUSED && item.key != KEY_START)) begin
                  // restart values
                  if (!down_ff) begin
                     count_in = '0;
                  end else begin
                     target_in = '0;
                     count_in  = reload_ff;
                  end
                  if (item.key != KEY_MINUS) mode_in = down_ff ? MODE_DOWN : MODE_UP;
               end else if (mode_ff == MODE_PAUSED) begin
                  mode_in = down_ff ? MODE_DOWN : MODE_UP;
               end
            end
            MODE_DOWN, MODE_UP: begin
               if (item.key == KEY_START) mode_in = MODE_PAUSED;
            end
            default: ;
         endcase
      end else if (step_en) begin
         unique case (mode_ff)
            MODE_EDIT_H: blink_in = (blink_ff == BLINK_HR)  ? BLINK_NONE : BLINK_HR;
            MODE_EDIT_M: blink_in = (blink_ff == BLINK_MIN) ? BLINK_NONE : BLINK_MIN;
            MODE_EDIT_S: blink_in = (blink_ff == BLINK_SEC) ? BLINK_NONE : BLINK_SEC;
            MODE_DOWN, MODE_UP: begin
               if (at_target) begin
                  if (!buzz_seen_ff) begin
                     buzz_on_in   = 1'b1;
                     buzz_seen_in = 1'b1;
                  end else begin
                     buzz_on_in = 1'b0;
                     mode_in    = MODE_STOPPED;
                  end
               end else begin
                  buzz_seen_in = 1'b0;
                  if (mode_ff == MODE_DOWN) begin
                     if (count_ff.s == 6'd0) begin
                        count_in.s = MS_LAST;
                        if (count_ff.m == 6'd0) begin
                           count_in.m = MS_LAST;
                           count_in.h = hr_dec(count_ff.h);
                        end else begin
                           count_in.m = count_ff.m - 6'd1;
                        end
                     end else begin
                        count_in.s = count_ff.s - 6'd1;
                     end
                  end else begin
                     count_in.s = sec_up;
                     if (sec_up == 6'd0) begin
                        count_in.m = min_up;
                        if (min_up == 6'd0) count_in.h = hr_inc(count_ff.h);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SELECT;
         down_ff      <= 1'b0;
         count_ff     <= '0;
         target_ff    <= '0;
         reload_ff    <= '0;
         buzz_seen_ff <= 1'b0;
         buzz_on_ff   <= 1'b0;
         blink_ff     <= BLINK_NONE;
      end else begin
         mode_ff      <= mode_in;
         down_ff      <= down_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         reload_ff    <= reload_in;
         buzz_seen_ff <= buzz_seen_in;
         buzz_on_ff   <= buzz_on_in;
         blink_ff     <= blink_in;
      end
   end

   // display of the updated state
   always_comb begin
      edit              = (mode_in == MODE_EDIT_H) || (mode_in == MODE_EDIT_M) ||
                          (mode_in == MODE_EDIT_S);
      disp.pad          = 2'b00;
      disp.mode         = mode_in;
      disp.direction    = down_in;
      disp.hours        = count_in.h;
      disp.minutes      = count_in.m;
      disp.seconds      = count_in.s;
      disp.hour_blank   = edit && (blink_in == BLINK_HR);
      disp.minute_blank = edit && (blink_in == BLINK_MIN);
      disp.second_blank = edit && (blink_in == BLINK_SEC);
      disp.colon_on     = edit || !count_in.s[0];
      disp.buzz         = buzz_on_in;
      disp.beep         = !edit && buzz_on_in && beep_enable;
   end

endmodule

>>> sv/up_down_interval_timer.sv
// Up/down hh:mm:ss interval timer driven by one-second ticks and key presses. One
// transfer in gives one transfer out with the display state after that item. The
// block takes an item every cycle while rsp_tready stays high: the state update for
// one item is combinational, between an input register and the result register.
// The result register frees as soon as its transfer completes, so a held result
// still lets the input register fill. Write csr_data only while no items are in
// flight.
// Depends on uditmr_pkg and uditmr_state.
module up_down_interval_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,     // beep_enable
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [1:0] key, [7:2] zero
   input  logic        req_tuser,    // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // mode, direction, hours, minutes, seconds,
                                     // hour_blank, minute_blank, second_blank,
                                     // colon_on, buzz, beep, zero pad
);
   import uditmr_pkg::*;

   logic     beep_en_ff;
   logic     in_valid_ff;
   item_type in_item_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   rsp_type  disp;
   logic     advance;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_en_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) beep_en_ff <= csr_data;
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.cmd <= req_tuser;
         in_item_ff.key <= key_type'(req_tdata[1:0]);
      end
      if (advance) rsp_data_ff <= disp;
   end

   uditmr_state u_state (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (in_item_ff),
      .beep_enable (beep_en_ff),
      .disp        (disp)
   );

   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach the result register");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.mode <= MODE_UP))
      else $error("result mode out of range");

   a_one_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.hour_blank, rsp_data_ff.minute_blank,
                                 rsp_data_ff.second_blank}))
      else $error("more than one field blanked");

   a_beep_buzz: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.beep) |-> rsp_data_ff.buzz)
      else $error("beep without buzz");

endmodule

>>> test/timer_display_checker.sv
`timescale 1ns / 100ps
// Checker for the up/down interval timer: mirrors the timer state, predicts the display
// word for every input transfer and compares it with each result transfer. Uses uditmr_pkg.
module timer_display_checker
   import uditmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count,
   output int          buzz_count,
   output int          beep_count,
   output mode_type    mode_now
);

   mode_type   tm_mode;
   logic       tm_down;
   hms_type    tm_count;
   hms_type    tm_target;
   hms_type    tm_reload;
   logic       tm_buzz_seen;
   logic       tm_buzz;
   logic [1:0] tm_blink;
   logic       tm_beep_en;

   rsp_type    display_q[$];
   rsp_type    got;
   rsp_type    want;

   function automatic int roll_up(int v, int last);
      return (v >= last) ? 0 : v + 1;
   endfunction

   function automatic int roll_down(int v, int last);
      return (v == 0) ? last : v - 1;
   endfunction

   function automatic string fmt(rsp_type r);
      return $sformatf("mode=%0d dir=%0d %0d:%0d:%0d blank=%b%b%b colon=%b buzz=%b beep=%b pad=%b",
                       r.mode, r.direction, r.hours, r.minutes, r.seconds, r.hour_blank,
                       r.minute_blank, r.second_blank, r.colon_on, r.buzz, r.beep, r.pad);
   endfunction

   function automatic mode_type run_mode();
      return tm_down ? MODE_DOWN : MODE_UP;
   endfunction

   task automatic launch_from_edit();
      if (!tm_down) begin
         tm_target = tm_count;
         tm_count  = '0;
      end else begin
         tm_target = '0;
         tm_reload = tm_count;
      end
      tm_mode = MODE_PAUSED;
   endtask

   task automatic restart_count();
      if (!tm_down) begin
         tm_count = '0;
      end else begin
         tm_target = '0;
         tm_count  = tm_reload;
      end
   endtask

   task automatic press_key(input key_type k);
      case (tm_mode)
         MODE_SELECT: begin
            case (k)
               KEY_ENTER: tm_mode = MODE_CLOCK;
               KEY_PLUS: begin
                  tm_down = 1'b0;
                  tm_mode = MODE_EDIT_H;
               end
               KEY_MINUS: begin
                  tm_down = 1'b1;
                  tm_mode = MODE_EDIT_H;
               end
               default: begin
                  tm_down  = 1'b0;
                  tm_count = '{h: START_HR, m: MS_LAST, s: MS_LAST};
                  launch_from_edit();
                  tm_mode = MODE_UP;
               end
            endcase
         end
         MODE_EDIT_H: begin
            case (k)
               KEY_PLUS:  tm_count.h = 7'(roll_up(tm_count.h, HOUR_LAST));
               KEY_MINUS: tm_count.h = 7'(roll_down(tm_count.h, HOUR_LAST));
               KEY_ENTER: tm_mode = MODE_EDIT_M;
               default:   launch_from_edit();
            endcase
         end
         MODE_EDIT_M: begin
            case (k)
               KEY_PLUS:  tm_count.m = 6'(roll_up(tm_count.m, MS_LAST));
               KEY_MINUS: tm_count.m = 6'(roll_down(tm_count.m, MS_LAST));
               KEY_ENTER: tm_mode = MODE_EDIT_S;
               default:   launch_from_edit();
            endcase
         end
         MODE_EDIT_S: begin
            case (k)
               KEY_PLUS:  tm_count.s = 6'(roll_up(tm_count.s, MS_LAST));
               KEY_MINUS: tm_count.s = 6'(roll_down(tm_count.s, MS_LAST));
               default:   launch_from_edit();
            endcase
         end
         MODE_STOPPED: begin
            if (k == KEY_ENTER) begin
               tm_mode = MODE_CLOCK;
            end else if (k == KEY_START) begin
               restart_count();
               tm_mode = run_mode();
            end
         end
         MODE_PAUSED: begin
            case (k)
               KEY_PLUS: begin
                  restart_count();
                  tm_mode = run_mode();
               end
               KEY_MINUS: restart_count();
               KEY_ENTER: tm_mode = MODE_CLOCK;
               default:   tm_mode = run_mode();
            endcase
         end
         MODE_DOWN, MODE_UP: begin
            if (k == KEY_START) tm_mode = MODE_PAUSED;
         end
         default: ;
      endcase
   endtask

   task automatic second_tick();
      case (tm_mode)
         MODE_EDIT_H: tm_blink = (tm_blink == BLINK_HR)  ? BLINK_NONE : BLINK_HR;
         MODE_EDIT_M: tm_blink = (tm_blink == BLINK_MIN) ? BLINK_NONE : BLINK_MIN;
         MODE_EDIT_S: tm_blink = (tm_blink == BLINK_SEC) ? BLINK_NONE : BLINK_SEC;
         MODE_DOWN, MODE_UP: begin
            if (tm_count == tm_target) begin
               if (!tm_buzz_seen) begin
                  tm_buzz      = 1'b1;
                  tm_buzz_seen = 1'b1;
               end else begin
                  tm_buzz = 1'b0;
                  tm_mode = MODE_STOPPED;
               end
            end else begin
               tm_buzz_seen = 1'b0;
               if (tm_mode == MODE_DOWN) begin
                  if (tm_count.s == 0) begin
                     tm_count.s = MS_LAST;
                     if (tm_count.m == 0) begin
                        tm_count.m = MS_LAST;
                        tm_count.h = 7'(roll_down(tm_count.h, HOUR_LAST));
                     end else begin
                        tm_count.m = tm_count.m - 6'd1;
                     end
                  end else begin
                     tm_count.s = tm_count.s - 6'd1;
                  end
               end else begin
                  tm_count.s = 6'(roll_up(tm_count.s, MS_LAST));
                  if (tm_count.s == 0) begin
                     tm_count.m = 6'(roll_up(tm_count.m, MS_LAST));
                     if (tm_count.m == 0) tm_count.h = 7'(roll_up(tm_count.h, HOUR_LAST));
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic step_timer(input logic is_key, input key_type k, output rsp_type d);
      logic editing;
      if (is_key) press_key(k);
      else second_tick();
      editing = (tm_mode == MODE_EDIT_H) || (tm_mode == MODE_EDIT_M) || (tm_mode == MODE_EDIT_S);
      d              = '0;
      d.mode         = tm_mode;
      d.direction    = tm_down;
      d.hours        = tm_count.h;
      d.minutes      = tm_count.m;
      d.seconds      = tm_count.s;
      d.hour_blank   = editing && (tm_blink == BLINK_HR);
      d.minute_blank = editing && (tm_blink == BLINK_MIN);
      d.second_blank = editing && (tm_blink == BLINK_SEC);
      d.colon_on     = editing || !tm_count.s[0];
      d.buzz         = tm_buzz;
      d.beep         = !editing && tm_buzz && tm_beep_en;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tm_mode        = MODE_SELECT;
         tm_down        = 1'b0;
         tm_count       = '0;
         tm_target      = '0;
         tm_reload      = '0;
         tm_buzz_seen   = 1'b0;
         tm_buzz        = 1'b0;
         tm_blink       = BLINK_NONE;
         tm_beep_en     = 1'b0;
         mismatch_count = 0;
         checked_count  = 0;
         buzz_count     = 0;
         beep_count     = 0;
         display_q.delete();
      end else begin
         if (csr_valid && csr_ready) tm_beep_en = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            if (display_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result transfer: %s", $realtime, fmt(got));
            end else begin
               want = display_q.pop_front();
               checked_count++;
               if (want.buzz) buzz_count++;
               if (want.beep) beep_count++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: display mismatch", $realtime);
                     $display("   expected %s", fmt(want));
                     $display("   actual   %s", fmt(got));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_timer(req_tuser, key_type'(req_tdata[1:0]), want);
            display_q.push_back(want);
         end
      end
      pending_count = display_q.size();
      mode_now      = tm_mode;
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Top of the up/down interval timer testbench: clock, reset, stimulus and verdict.
// Depends on uditmr_pkg, up_down_interval_timer and timer_display_checker.
module tb;
   import uditmr_pkg::*;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_KEY     = 1'b1;
   localparam int   QUIET_LIMIT = 1000;
   localparam int   PHASE_ITEMS = 360;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   int       send_idle;
   int       recv_stall;
   int       items_sent;
   int       quiet_cycles = 0;
   int       path;
   int       fails;
   int       expected_left;
   int       checked;
   int       buzzes;
   int       beeps;
   mode_type mode_now;

   up_down_interval_timer DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   timer_display_checker display_chk (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (fails),
      .pending_count  (expected_left),
      .checked_count  (checked),
      .buzz_count     (buzzes),
      .beep_count     (beeps),
      .mode_now       (mode_now)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("up_down_interval_timer test failed");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_item(input logic c, input key_type k);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {6'b0, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_beep(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_left != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly well-formed run/pause/restart traffic; enter only where it is ignored
   task automatic pick_item(output logic c, output key_type k);
      int r;
      r = $urandom_range(99);
      c = CMD_TICK;
      k = key_type'($urandom_range(3));
      case (mode_now)
         MODE_UP, MODE_DOWN: begin
            if (r < 2) begin
               c = CMD_KEY;
               k = KEY_START;
            end else if (r < 6) begin
               c = CMD_KEY;
               k = key_type'($urandom_range(2));
            end
         end
         MODE_PAUSED: begin
            c = CMD_KEY;
            if (r < 50) k = KEY_START;
            else if (r < 65) k = KEY_PLUS;
            else if (r < 75) k = KEY_MINUS;
            else c = CMD_TICK;
         end
         MODE_STOPPED: begin
            c = CMD_KEY;
            if (r < 50) k = KEY_START;
            else if (r < 65) k = key_type'($urandom_range(2, 1));
            else c = CMD_TICK;
         end
         default: ;
      endcase
   endtask

   initial begin
      logic    c;
      key_type k;
      int      n;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_TICK;
      rsp_tready = 1'b0;
      send_idle  = 0;
      recv_stall = 0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_beep(1'b1);

      // directed: one pass out of select, which cannot be re-entered
      path = $urandom_range(4);
      send_item(CMD_TICK, KEY_START);
      if (path == 0) begin
         send_item(CMD_KEY, KEY_START);
         repeat (3) send_item(CMD_TICK, KEY_ENTER);
         send_item(CMD_KEY, KEY_PLUS);
         send_item(CMD_KEY, KEY_START);
         send_item(CMD_TICK, KEY_MINUS);
         send_item(CMD_KEY, KEY_MINUS);
         send_item(CMD_KEY, KEY_PLUS);
         repeat (2) send_item(CMD_TICK, KEY_PLUS);
         send_item(CMD_KEY, KEY_START);
         send_item(CMD_KEY, KEY_START);
      end else begin
         send_item(CMD_KEY, (path <= 2) ? KEY_PLUS : KEY_MINUS);
         send_item(CMD_TICK, KEY_ENTER);
         send_item(CMD_KEY, KEY_MINUS);
         send_item(CMD_TICK, KEY_PLUS);
         send_item(CMD_TICK, KEY_MINUS);
         send_item(CMD_KEY, KEY_PLUS);
         send_item(CMD_KEY, KEY_ENTER);
         send_item(CMD_TICK, KEY_START);
         send_item(CMD_KEY, KEY_MINUS);
         send_item(CMD_KEY, KEY_PLUS);
         if ($urandom_range(3) == 0) send_item(CMD_KEY, KEY_PLUS);
         send_item(CMD_KEY, KEY_ENTER);
         send_item(CMD_TICK, KEY_ENTER);
         send_item(CMD_TICK, KEY_ENTER);
         send_item(CMD_KEY, KEY_MINUS);
         send_item(CMD_KEY, KEY_PLUS);
         n = $urandom_range(8);
         repeat (n) send_item(CMD_KEY, KEY_PLUS);
         send_item(CMD_KEY, $urandom_range(1) ? KEY_START : KEY_ENTER);
         send_item(CMD_TICK, KEY_PLUS);
         send_item(CMD_KEY, KEY_START);
      end
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_beep((phase == 3) ? 1'($urandom_range(1)) : ~phase[0]);
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 52; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 52; end
            default: begin send_idle = 29; recv_stall = 29; end
         endcase
         repeat (PHASE_ITEMS) begin
            pick_item(c, k);
            send_item(c, k);
         end
         req_tvalid <= 1'b0;
      end

      // park in clock mode, where no key or tick changes the state
      while (mode_now != MODE_CLOCK)
         send_item(CMD_KEY, (mode_now == MODE_UP || mode_now == MODE_DOWN) ? KEY_START : KEY_ENTER);
      repeat (6) send_item(1'($urandom_range(1)), key_type'($urandom_range(3)));
      req_tvalid <= 1'b0;

      while (expected_left != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d items on the %s path through four pressure phases.", items_sent,
               (path == 0) ? "start-from-select" : (path <= 2) ? "count-up edit" : "count-down edit");
      $display("Compared %0d display words; %0d showed buzz, %0d drove the beeper.",
               checked, buzzes, beeps);
      if (fails == 0) begin
         $display("up_down_interval_timer test passed");
      end else begin
         $display("%0d mismatches", fails);
         $display("up_down_interval_timer test failed");
      end
      $finish;
   end

endmodule
